// ===== hdl/bke_pkg.sv =====
// Shared constants, types and the key alphabet lookup for the base32 key encoder.
package bke_pkg;

  localparam int unsigned TotalBitsW      = 11;
  localparam int unsigned BitsToCut       = 5;
  localparam int unsigned NumOut          = 3;
  localparam int unsigned MaxFrameBitsDef = 1024;
  localparam logic [TotalBitsW-1:0] TotalBitsReset = 11'd100;

  // One encoded symbol.
  typedef struct packed {
    logic [4:0] code;
    logic       last;
  } sym_t;

  // All symbols that one request produces, in order, with their count.
  typedef struct packed {
    logic [1:0]              num;
    sym_t [NumOut-1:0]       syms;
  } step_res_t;

  // Key alphabet: T2QZ34GF6BRCDEW5H8JKL7MNP9SUVAXY.
  function automatic logic [6:0] key_char(input logic [4:0] code);
    logic [6:0] ch;
    case (code)
      5'd0:    ch = 7'h54;
      5'd1:    ch = 7'h32;
      5'd2:    ch = 7'h51;
      5'd3:    ch = 7'h5A;
      5'd4:    ch = 7'h33;
      5'd5:    ch = 7'h34;
      5'd6:    ch = 7'h47;
      5'd7:    ch = 7'h46;
      5'd8:    ch = 7'h36;
      5'd9:    ch = 7'h42;
      5'd10:   ch = 7'h52;
      5'd11:   ch = 7'h43;
      5'd12:   ch = 7'h44;
      5'd13:   ch = 7'h45;
      5'd14:   ch = 7'h57;
      5'd15:   ch = 7'h35;
      5'd16:   ch = 7'h48;
      5'd17:   ch = 7'h38;
      5'd18:   ch = 7'h4A;
      5'd19:   ch = 7'h4B;
      5'd20:   ch = 7'h4C;
      5'd21:   ch = 7'h37;
      5'd22:   ch = 7'h4D;
      5'd23:   ch = 7'h4E;
      5'd24:   ch = 7'h50;
      5'd25:   ch = 7'h39;
      5'd26:   ch = 7'h53;
      5'd27:   ch = 7'h55;
      5'd28:   ch = 7'h56;
      5'd29:   ch = 7'h41;
      5'd30:   ch = 7'h58;
      5'd31:   ch = 7'h59;
      default: ch = 7'h54;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/base32_key_encoder.sv =====
// A byte taken into the input register is encoded and written into a result slot once
// one is free; its symbols are then presented from that slot in order.
// Throughput: one byte per cycle enters while a result slot is free; the output gives
// one symbol per cycle while out_ready_i is high, and a byte yields up to three symbols.
// Two result slots of three symbols each let input run while output drains.
// Reset: asynchronous, active low; clears the frame state, empties all slots
// and loads total_bits with 100.
module base32_key_encoder import bke_pkg::*; #(
  parameter int unsigned MaxFrameBits = MaxFrameBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TotalBitsW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [6:0]            key_char_o,
  output logic [4:0]            symbol_code_o,
  output logic                  last_symbol_o
);

  localparam int unsigned CntW = $clog2(MaxFrameBits + BitsToCut);

  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  in_last_q;
  logic [TotalBitsW-1:0] total_bits_q;
  logic [3:0]            lbits_q, lbits_d;
  logic [2:0]            lcnt_q, lcnt_d;
  logic [CntW-1:0]       sent_q, sent_d;
  logic                  done_q, done_d;
  step_res_t             res;
  step_res_t             slot_q [2];
  logic [1:0]            slot_vld_q;
  logic [1:0]            slot_vld_d;
  logic                  wr_q;
  logic                  rd_q;
  logic [1:0]            idx_q;
  logic                  adv;
  logic                  slot_wr;
  logic                  out_fire;
  logic                  slot_end;
  sym_t                  cur_sym;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_bits_q <= TotalBitsReset;
    end else if (cfg_we_i) begin
      total_bits_q <= cfg_wdata_i;
    end
  end

  // Input register; it moves on when a slot is free or the byte yields nothing.
  assign adv        = in_vld_q && (!slot_vld_q[wr_q] || (res.num == 2'd0));
  assign slot_wr    = adv && (res.num != 2'd0);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Encode step.
  bke_step #(
    .MaxFrameBits (MaxFrameBits),
    .CntW         (CntW)
  ) u_step (
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .total_bits_i (total_bits_q),
    .lbits_i      (lbits_q),
    .lcnt_i       (lcnt_q),
    .sent_i       (sent_q),
    .done_i       (done_q),
    .res_o        (res),
    .lbits_o      (lbits_d),
    .lcnt_o       (lcnt_d),
    .sent_o       (sent_d),
    .done_o       (done_d)
  );

  // Frame state advances with each byte that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbits_q <= '0;
      lcnt_q  <= '0;
      sent_q  <= '0;
      done_q  <= 1'b0;
    end else if (adv) begin
      lbits_q <= lbits_d;
      lcnt_q  <= lcnt_d;
      sent_q  <= sent_d;
      done_q  <= done_d;
    end
  end

  // Result slots: written whole, drained one symbol at a time.
  assign cur_sym  = slot_q[rd_q].syms[idx_q];
  assign out_fire = out_valid_o && out_ready_i;
  assign slot_end = (idx_q == (slot_q[rd_q].num - 2'd1));

  always_ff @(posedge clk_i) begin
    if (slot_wr) begin
      slot_q[wr_q] <= res;
    end
  end

  // Slot occupancy: the drained slot empties, the written slot fills.
  always_comb begin
    slot_vld_d = slot_vld_q;
    if (out_fire && slot_end) begin
      slot_vld_d[rd_q] = 1'b0;
    end
    if (slot_wr) begin
      slot_vld_d[wr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
      idx_q      <= '0;
    end else begin
      slot_vld_q <= slot_vld_d;
      if (out_fire) begin
        if (slot_end) begin
          rd_q  <= !rd_q;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      if (slot_wr) begin
        wr_q <= !wr_q;
      end
    end
  end

  // Output symbol.
  assign out_valid_o   = slot_vld_q[rd_q];
  assign symbol_code_o = cur_sym.code;
  assign last_symbol_o = cur_sym.last;
  assign key_char_o    = key_char(cur_sym.code);

  // A filled slot always holds at least one symbol.
  a_slot_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (slot_q[rd_q].num != 2'd0))
    else $error("occupied result slot holds no symbols");

  // The drain index stays inside the current slot.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < slot_q[rd_q].num))
    else $error("drain index beyond slot contents");

  // A last byte leaves a clean frame behind.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> ((sent_q == '0) && !done_q && (lcnt_q == '0)))
    else $error("frame state not cleared after last byte");

  // At most four bits are ever buffered.
  a_leftover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcnt_q <= 3'd4)
    else $error("leftover bit count out of range");

  // Only the final symbol of a slot may carry the frame end flag.
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_symbol_o) |-> slot_end)
    else $error("frame end flag not on the slot's final symbol");

endmodule

// ===== hdl/bke_step.sv =====
// Combinational encode step: cuts one byte plus buffered bits into symbols.
module bke_step import bke_pkg::*; #(
  parameter int unsigned MaxFrameBits = MaxFrameBitsDef,
  parameter int unsigned CntW         = $clog2(MaxFrameBits + BitsToCut)
) (
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  input  logic [TotalBitsW-1:0] total_bits_i,
  input  logic [3:0]            lbits_i,
  input  logic [2:0]            lcnt_i,
  input  logic [CntW-1:0]       sent_i,
  input  logic                  done_i,
  output step_res_t             res_o,
  output logic [3:0]            lbits_o,
  output logic [2:0]            lcnt_o,
  output logic [CntW-1:0]       sent_o,
  output logic                  done_o
);

  localparam int unsigned CmpW = (CntW > TotalBitsW) ? CntW : TotalBitsW;

  logic [CmpW-1:0] tb_ext;
  logic [CmpW-1:0] tb_lim;
  logic [CmpW-1:0] sent0;
  logic [CmpW-1:0] sent1;
  logic [CmpW-1:0] sent2;
  logic            done0;
  logic            done1;
  logic            done2;
  logic [11:0]     acc;
  logic [3:0]      count;
  logic [3:0]      sh0;
  logic [3:0]      sh1;
  logic [4:0]      code0;
  logic [4:0]      code1;
  logic            two_fit;
  logic [3:0]      rem;
  logic [3:0]      lb_new;
  logic [2:0]      lc_new;
  logic            done_new;
  logic [CmpW-1:0] sent_new;
  logic [8:0]      flush_wide;

  // Symbol budget is kept in bits: a frame ends once 5 * symbols >= limited total.
  assign tb_ext = CmpW'(total_bits_i);
  assign tb_lim = (tb_ext > CmpW'(MaxFrameBits)) ? CmpW'(MaxFrameBits) : tb_ext;
  assign sent0  = CmpW'(sent_i);
  assign sent1  = sent0 + CmpW'(BitsToCut);
  assign sent2  = sent1 + CmpW'(BitsToCut);
  assign done0  = done_i || (sent0 >= tb_lim);
  assign done1  = sent1 >= tb_lim;
  assign done2  = sent2 >= tb_lim;

  // Bit accumulator: buffered bits on top, the new byte below.
  assign acc     = {lbits_i, byte_i};
  assign count   = {1'b0, lcnt_i} + 4'd8;
  assign sh0     = count - 4'(BitsToCut);
  assign sh1     = count - 4'(2 * BitsToCut);
  assign code0   = 5'(acc >> sh0);
  assign code1   = 5'(acc >> sh1);
  assign two_fit = count >= 4'(2 * BitsToCut);

  // Regular symbols, remainder, and the zero-padded flush symbol.
  always_comb begin
    res_o    = '0;
    rem      = count - 4'(BitsToCut);
    done_new = done0;
    sent_new = sent0;
    lb_new   = lbits_i;
    lc_new   = lcnt_i;
    flush_wide = '0;
    if (!done0) begin
      res_o.num          = 2'd1;
      res_o.syms[0].code = code0;
      res_o.syms[0].last = done1;
      done_new           = done1;
      sent_new           = sent1;
      if (!done1 && two_fit) begin
        res_o.num          = 2'd2;
        res_o.syms[1].code = code1;
        res_o.syms[1].last = done2;
        done_new           = done2;
        sent_new           = sent2;
        rem                = sh1;
      end
      if (done_new) begin
        lb_new = '0;
        lc_new = '0;
      end else begin
        lc_new = rem[2:0];
        lb_new = acc[3:0] & ((4'd1 << rem) - 4'd1);
      end
      if (last_i && !done_new) begin
        flush_wide = 9'(lb_new) << (3'(BitsToCut) - lc_new);
        if (res_o.num == 2'd1) begin
          res_o.syms[1].code = flush_wide[4:0];
          res_o.syms[1].last = 1'b1;
          res_o.num          = 2'd2;
        end else begin
          res_o.syms[2].code = flush_wide[4:0];
          res_o.syms[2].last = 1'b1;
          res_o.num          = 2'd3;
        end
      end
    end
  end

  // A last byte always restarts the frame.
  always_comb begin
    if (last_i) begin
      lbits_o = '0;
      lcnt_o  = '0;
      sent_o  = '0;
      done_o  = 1'b0;
    end else begin
      lbits_o = lb_new;
      lcnt_o  = lc_new;
      sent_o  = CntW'(sent_new);
      done_o  = done_new;
    end
  end

endmodule

// ===== tb/base32_key_encoder_test.sv =====
// Self-checking base32 key encoder testbench: directed and randomized frames against a predictor.
module base32_key_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string KeyLetters  = "T2QZ34GF6BRCDEW5H8JKL7MNP9SUVAXY";
  localparam int    QuietLimit  = 500;
  localparam int    SettleTicks = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [6:0] key_char;
    logic [4:0] code;
    logic       last;
  } symbol_t;

  typedef enum logic [1:0] {ReadyAlways, ReadyHalf, ReadyQuarter, ReadyPattern} ready_mode_e;
  typedef enum logic [1:0] {FrameFull, FrameTrailing, FrameEarly} frame_kind_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [bke_pkg::TotalBitsW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [7:0]                     data_byte_i = '0;
  logic                           last_byte_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [6:0]                     key_char_o;
  logic [4:0]                     symbol_code_o;
  logic                           last_symbol_o;

  // Requests waiting to be driven and symbols waiting to come out.
  byte_req_t bytes_to_send[$];
  symbol_t   symbols_due[$];

  // Encoder state as the predictor tracks it.
  logic [bke_pkg::TotalBitsW-1:0] enc_total_bits = bke_pkg::TotalBitsReset;
  logic [3:0]                     enc_rem_bits   = '0;
  logic [2:0]                     enc_rem_count  = '0;
  int unsigned                    enc_sent       = 0;
  logic                           enc_done       = 1'b0;

  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          gap_left       = 0;
  int          burst_left     = 0;
  int          stall_step     = 0;
  ready_mode_e stall_mode     = ReadyAlways;
  logic [7:0]  stall_pattern  = '1;
  int unsigned random_bytes   = 0;

  base32_key_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_char_o    (key_char_o),
    .symbol_code_o (symbol_code_o),
    .last_symbol_o (last_symbol_o)
  );

  always #2ns clk_i = ~clk_i;

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic push_symbol(input logic [4:0] code, input logic last);
    symbols_due.push_back('{key_char: 7'(KeyLetters[code]), code: code, last: last});
  endtask

  // Cut the byte into 5-bit groups behind any buffered bits, flag the last owed
  // group, and flush the padded remainder on an early last byte.
  task automatic encode_byte(input logic [7:0] data, input logic last);
    int unsigned capped;
    int unsigned owed;
    int unsigned count;
    int unsigned acc;
    capped = (enc_total_bits > bke_pkg::MaxFrameBitsDef) ? bke_pkg::MaxFrameBitsDef
                                                         : enc_total_bits;
    owed = (capped + bke_pkg::BitsToCut - 1) / bke_pkg::BitsToCut;
    if (!enc_done && enc_sent >= owed) enc_done = 1'b1;
    if (!enc_done) begin
      count = enc_rem_count + 8;
      acc   = {enc_rem_bits, data};
      while (count >= bke_pkg::BitsToCut && !enc_done) begin
        count -= bke_pkg::BitsToCut;
        enc_sent++;
        if (enc_sent >= owed) enc_done = 1'b1;
        push_symbol(5'(acc >> count), enc_done);
      end
      if (enc_done) begin
        enc_rem_bits  = '0;
        enc_rem_count = '0;
      end else begin
        enc_rem_bits  = 4'(acc & ((1 << count) - 1));
        enc_rem_count = 3'(count);
      end
      if (last && !enc_done) begin
        push_symbol(5'({1'b0, enc_rem_bits} << (bke_pkg::BitsToCut - enc_rem_count)), 1'b1);
      end
    end
    // Any last byte starts a fresh frame.
    if (last) begin
      enc_rem_bits  = '0;
      enc_rem_count = '0;
      enc_sent      = 0;
      enc_done      = 1'b0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    bytes_to_send.push_back('{data: data, last: last});
  endtask

  // Queue one frame for the given bit count: complete, with ignored trailing
  // bytes, or cut short by an early last byte.
  task automatic queue_frame(input int unsigned bits, input frame_kind_e kind);
    int unsigned capped;
    int unsigned owed;
    int unsigned need;
    int unsigned len;
    logic [7:0]  data;
    capped = (bits > bke_pkg::MaxFrameBitsDef) ? bke_pkg::MaxFrameBitsDef : bits;
    owed   = (capped + bke_pkg::BitsToCut - 1) / bke_pkg::BitsToCut;
    need   = (owed * bke_pkg::BitsToCut + 7) / 8;
    len    = need;
    if (need == 0) begin
      len = $urandom_range(1, 2);
    end else if (kind == FrameTrailing) begin
      len = need + $urandom_range(1, 3);
    end else if (kind == FrameEarly) begin
      len = $urandom_range(1, (need > 12) ? 12 : need);
    end
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        data = 8'($urandom());
      end
      queue_byte(data, i == len - 1);
    end
    random_bytes += len;
  endtask

  // Hold off until every queued request is taken and every symbol has come out.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid_i || symbols_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic set_total_bits(input logic [bke_pkg::TotalBitsW-1:0] bits);
    cfg_wdata_i <= bits;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    enc_total_bits  = bits;
    @(negedge clk_i);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin : drive_requests
    logic      next_valid;
    byte_req_t req;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) encode_byte(data_byte_i, last_byte_i);
      next_valid = in_valid_i && !in_ready_o;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (bytes_to_send.size() > 0) begin
          req = bytes_to_send.pop_front();
          data_byte_i <= req.data;
          last_byte_i <= req.last;
          next_valid   = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Output back-pressure: a randomly chosen stall mode, picked anew whenever the step counter runs out.
  always @(posedge clk_i) begin : pace_output
    if (stall_step == 0) begin
      stall_mode    = ready_mode_e'($urandom_range(0, 3));
      stall_pattern = 8'($urandom());
      stall_step    = 24;
    end
    stall_step--;
    case (stall_mode)
      ReadyAlways:  out_ready_i <= 1'b1;
      ReadyHalf:    out_ready_i <= 1'($urandom_range(0, 1));
      ReadyQuarter: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:      out_ready_i <= stall_pattern[stall_step % 8];
    endcase
  end

  // Compare each symbol that leaves the block with the oldest prediction.
  always @(posedge clk_i) begin : check_symbols
    symbol_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (symbols_due.size() == 0) begin
        note_mismatch($sformatf("unexpected symbol: code %0d char %02h last %0b",
                                symbol_code_o, key_char_o, last_symbol_o));
      end else begin
        want = symbols_due.pop_front();
        if (want.code !== symbol_code_o || want.key_char !== key_char_o ||
            want.last !== last_symbol_o) begin
          note_mismatch($sformatf(
            "symbol: expected code %0d char %02h last %0b, got code %0d char %02h last %0b",
            want.code, want.key_char, want.last, symbol_code_o, key_char_o, last_symbol_o));
        end
      end
    end
  end

  // Stop the run when neither side moves for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no request or symbol moved for %0d cycles", QuietLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned bits;
    int unsigned frames;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset width of 100 bits: extremes, then an early last byte with nothing buffered.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h7E, 1'b1);
    wait_idle();

    // One-bit frame: completes at once, later bytes are ignored until a last byte.
    set_total_bits(11'd1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b1);
    queue_byte(8'h80, 1'b1);
    wait_idle();

    // Zero bits: nothing is owed at all.
    set_total_bits(11'd0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b1);
    wait_idle();

    // Thirteen bits: completion on the second byte, then an early last with three bits buffered.
    set_total_bits(11'd13);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h3C, 1'b1);
    queue_byte(8'hC3, 1'b1);
    wait_idle();

    // Largest frame and a value above it, both cut short.
    set_total_bits(11'd1024);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hA5, 1'b1);
    wait_idle();
    set_total_bits(11'd2047);
    queue_byte(8'h0F, 1'b1);
    wait_idle();

    // Longer frames above and at the limit, each ended early at a random point.
    set_total_bits(11'd2047);
    queue_frame(2047, FrameEarly);
    wait_idle();
    set_total_bits(11'd1024);
    queue_frame(1024, FrameEarly);
    wait_idle();

    // Random widths, mostly short, with a few frames each.
    random_bytes = 0;
    while (random_bytes < 100) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        bits = 0;
      end else if (pick == 1) begin
        bits = $urandom_range(1, 5);
      end else begin
        bits = $urandom_range(1, 48);
      end
      set_total_bits(bits[bke_pkg::TotalBitsW-1:0]);
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        pick = $urandom_range(0, 9);
        queue_frame(bits, (pick < 6) ? FrameFull : (pick < 8) ? FrameTrailing : FrameEarly);
      end
      wait_idle();
    end

    if (mismatch_count == 0 && symbols_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== base32_key_encoder.f =====
hdl/bke_pkg.sv
hdl/bke_step.sv
hdl/base32_key_encoder.sv
tb/base32_key_encoder_test.sv
